[sv/otpg_pkg.sv]
// ----------------------------------------------------------------------------
// otpg_pkg
// Shared types, constants and font tables of the OSD text pixel generator.
// ----------------------------------------------------------------------------
package otpg_pkg;

  localparam int MAX_CHARS_DEF = 64;

  // port widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 24;

  // item kinds on in_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_FONT_SIZE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FONT_COLOR = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BG_ON      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TEXT_LEN   = 2'd3;

  // configuration reset values
  localparam logic [6:0]  FONT_SIZE_RST  = 7'd24;
  localparam logic [23:0] FONT_COLOR_RST = 24'hFFFFFF;
  localparam logic        BG_ON_RST      = 1'b1;
  localparam logic [6:0]  TEXT_LEN_RST   = 7'd0;

  // geometry
  localparam logic [11:0] PAD_X      = 12'd4;
  localparam logic [6:0]  PAD_Y      = 7'd3;
  localparam logic [13:0] PAD_XX_RND = 14'd9;
  localparam logic [6:0]  PAD_YY_RND = 7'd7;
  localparam logic [13:0] WIDTH_MAX  = 14'd4094;
  localparam logic [6:0]  HEIGHT_MAX = 7'd126;

  localparam logic [15:0] PIX_ALPHA = 16'h8000;

  // reciprocals are floor(2^RECIP_SHIFT / d)
  localparam int RECIP_SHIFT = 15;

  // character codes
  localparam logic [7:0] CODE_SPACE  = 8'h20;
  localparam logic [7:0] CODE_0      = 8'h30;
  localparam logic [7:0] CODE_9      = 8'h39;
  localparam logic [7:0] CODE_A      = 8'h41;
  localparam logic [7:0] CODE_Z      = 8'h5a;
  localparam logic [7:0] CODE_LA     = 8'h61;
  localparam logic [7:0] CODE_LZ     = 8'h7a;
  localparam logic [7:0] CODE_COLON  = 8'h3a;
  localparam logic [7:0] CODE_DASH   = 8'h2d;
  localparam logic [7:0] CODE_SLASH  = 8'h2f;
  localparam logic [7:0] CODE_DOT    = 8'h2e;
  localparam logic [7:0] CODE_UNDER  = 8'h5f;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // glyph numbers
  localparam logic [5:0] GLYPH_ALPHA = 6'd10;
  localparam logic [5:0] GLYPH_COLON = 6'd36;
  localparam logic [5:0] GLYPH_DASH  = 6'd37;
  localparam logic [5:0] GLYPH_SLASH = 6'd38;
  localparam logic [5:0] GLYPH_DOT   = 6'd39;
  localparam logic [5:0] GLYPH_UNDER = 6'd40;
  localparam logic [5:0] GLYPH_BOX   = 6'd41;

  // seven rows of five bits, top row in the highest bits, left column as msb
  typedef logic [34:0] glyph_t;

  localparam glyph_t GLYPH_ROM [42] = '{
    {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
    {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
    {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31},
    {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30},
    {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2},
    {5'd31, 5'd16, 5'd30, 5'd1,  5'd1,  5'd17, 5'd14},
    {5'd6,  5'd8,  5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
    {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8},
    {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
    {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd2,  5'd12},
    {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
    {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
    {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
    {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
    {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
    {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14},
    {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    {5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
    {5'd1,  5'd1,  5'd1,  5'd1,  5'd17, 5'd17, 5'd14},
    {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
    {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
    {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
    {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
    {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
    {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
    {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
    {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30},
    {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4},
    {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
    {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
    {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17},
    {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4},
    {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31},
    {5'd0,  5'd4,  5'd4,  5'd0,  5'd4,  5'd4,  5'd0},
    {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0},
    {5'd1,  5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd16},
    {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12},
    {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd31},
    {5'd31, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd31}
  };

  // glyph scale from font size, size clamped into 8..72 first
  function automatic logic [3:0] scale_of(input logic [6:0] fs);
    logic [3:0] s;
    if (fs inside {[7'd0:7'd13]})       s = 4'd1;
    else if (fs inside {[7'd14:7'd20]}) s = 4'd2;
    else if (fs inside {[7'd21:7'd27]}) s = 4'd3;
    else if (fs inside {[7'd28:7'd34]}) s = 4'd4;
    else if (fs inside {[7'd35:7'd41]}) s = 4'd5;
    else if (fs inside {[7'd42:7'd48]}) s = 4'd6;
    else if (fs inside {[7'd49:7'd55]}) s = 4'd7;
    else if (fs inside {[7'd56:7'd62]}) s = 4'd8;
    else if (fs inside {[7'd63:7'd69]}) s = 4'd9;
    else                                s = 4'd10;
    return s;
  endfunction

  function automatic logic [15:0] recip_scale(input logic [3:0] s);
    logic [15:0] r;
    case (s)
      4'd1:    r = 16'd32768;
      4'd2:    r = 16'd16384;
      4'd3:    r = 16'd10922;
      4'd4:    r = 16'd8192;
      4'd5:    r = 16'd6553;
      4'd6:    r = 16'd5461;
      4'd7:    r = 16'd4681;
      4'd8:    r = 16'd4096;
      4'd9:    r = 16'd3640;
      4'd10:   r = 16'd3276;
      default: r = 16'd32768;
    endcase
    return r;
  endfunction

  // reciprocal of the character pitch, six times the scale
  function automatic logic [15:0] recip_pitch(input logic [3:0] s);
    logic [15:0] r;
    case (s)
      4'd1:    r = 16'd5461;
      4'd2:    r = 16'd2730;
      4'd3:    r = 16'd1820;
      4'd4:    r = 16'd1365;
      4'd5:    r = 16'd1092;
      4'd6:    r = 16'd910;
      4'd7:    r = 16'd780;
      4'd8:    r = 16'd682;
      4'd9:    r = 16'd606;
      4'd10:   r = 16'd546;
      default: r = 16'd5461;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] glyph_row(input logic [7:0] code, input logic [2:0] row);
    logic [7:0] c;
    logic [5:0] g;
    glyph_t     gl;
    logic [4:0] bits;
    c = code;
    if (c inside {[CODE_LA:CODE_LZ]}) c = c - CASE_OFFSET;
    if (c inside {[CODE_0:CODE_9]}) begin
      g = 6'(c - CODE_0);
    end else if (c inside {[CODE_A:CODE_Z]}) begin
      g = 6'(c - CODE_A) + GLYPH_ALPHA;
    end else begin
      case (c)
        CODE_COLON: g = GLYPH_COLON;
        CODE_DASH:  g = GLYPH_DASH;
        CODE_SLASH: g = GLYPH_SLASH;
        CODE_DOT:   g = GLYPH_DOT;
        CODE_UNDER: g = GLYPH_UNDER;
        default:    g = GLYPH_BOX;
      endcase
    end
    gl = GLYPH_ROM[g];
    case (row)
      3'd0:    bits = gl[34:30];
      3'd1:    bits = gl[29:25];
      3'd2:    bits = gl[24:20];
      3'd3:    bits = gl[19:15];
      3'd4:    bits = gl[14:10];
      3'd5:    bits = gl[9:5];
      3'd6:    bits = gl[4:0];
      default: bits = gl[34:30]; // row seven wraps to the top row
    endcase
    if (code == CODE_SPACE) bits = '0;
    return bits;
  endfunction

endpackage

[sv/otpg_ram.sv]
// ----------------------------------------------------------------------------
// otpg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module otpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/osd_text_pixel_generator.sv]
// ----------------------------------------------------------------------------
// osd_text_pixel_generator
// OSD character generator with a 5x7 font: stores text, returns ARGB1555 pixels.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  in_     | in  | tvalid / tready   | tuser: op; tdata: char_index, char_code,
//          |     |                   |   pixel_x, pixel_y
//  out_    | out | tvalid / tready   | tdata: pixel, inside_res, bitmap_width,
//          |     |                   |   bitmap_height
//  cfg_    | in  | we (no back-pres) | addr: register index; wdata: value
//
//  one item per cycle unless stalled; in_ items pass four pipeline stages and
//  the output register to out_tvalid (text store read in stage 3)
//  the pipeline moves as one: it stalls only while an output item waits
//  reset is synchronous and clears valid bits and configuration
//  text store content is undefined until written; no clearing pass
// ----------------------------------------------------------------------------
module osd_text_pixel_generator #(
  parameter int MAX_CHARS = otpg_pkg::MAX_CHARS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [5:0] char_index, [13:6] char_code, [25:14] pixel_x, [32:26] pixel_y
  input  logic [otpg_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] op
  input  logic [0:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] pixel, [16] inside_res, [28:17] bitmap_width, [35:29] bitmap_height
  output logic [otpg_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_we,
  input  logic [otpg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [otpg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import otpg_pkg::*;

  localparam int ADDR_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int LEN_W  = $clog2(MAX_CHARS + 1);
  localparam int TW_W   = 14;

  // configuration and derived geometry
  logic [6:0]       font_size_r, font_size_nxt;
  logic [23:0]      font_color_r, font_color_nxt;
  logic             bg_on_r, bg_on_nxt;
  logic [6:0]       text_len_r, text_len_nxt;

  logic [3:0]       scale_r, scale_nxt;
  logic [5:0]       pitch_r, pitch_nxt;
  logic [5:0]       five_s_r, five_s_nxt;
  logic [6:0]       seven_s_r, seven_s_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [TW_W-1:0]  wtrue_r, wtrue_nxt;
  logic [TW_W-1:0]  tw_nxt;
  logic [11:0]      wrep_r, wrep_nxt;
  logic [6:0]       height_r, height_nxt;
  logic [6:0]       hrep_r, hrep_nxt;
  logic [15:0]      recip_s_r, recip_s_nxt;
  logic [15:0]      recip_p_r, recip_p_nxt;
  logic [15:0]      fg_r, fg_nxt;
  logic [15:0]      bg_r, bg_nxt;

  always_comb begin
    font_size_nxt  = font_size_r;
    font_color_nxt = font_color_r;
    bg_on_nxt      = bg_on_r;
    text_len_nxt   = text_len_r;
    if (!rst_n) begin
      font_size_nxt  = FONT_SIZE_RST;
      font_color_nxt = FONT_COLOR_RST;
      bg_on_nxt      = BG_ON_RST;
      text_len_nxt   = TEXT_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FONT_SIZE:  font_size_nxt  = cfg_wdata[6:0];
        REG_FONT_COLOR: font_color_nxt = cfg_wdata[23:0];
        REG_BG_ON:      bg_on_nxt      = cfg_wdata[0];
        REG_TEXT_LEN:   text_len_nxt   = cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // geometry follows the next register values so it is valid in the same cycle
  always_comb begin
    scale_nxt   = scale_of(font_size_nxt);
    pitch_nxt   = {2'b0, scale_nxt} * 6'd6;
    five_s_nxt  = {2'b0, scale_nxt} * 6'd5;
    seven_s_nxt = {3'b0, scale_nxt} * 7'd7;
    if ({2'b0, text_len_nxt} > 9'(MAX_CHARS)) len_nxt = LEN_W'(MAX_CHARS);
    else                                      len_nxt = LEN_W'(text_len_nxt);
    if (len_nxt == '0) tw_nxt = TW_W'(five_s_nxt);
    else               tw_nxt = TW_W'(len_nxt) * TW_W'(pitch_nxt) - TW_W'(scale_nxt);
    wtrue_nxt   = (tw_nxt + PAD_XX_RND) & ~14'd1;
    wrep_nxt    = (wtrue_nxt > WIDTH_MAX) ? WIDTH_MAX[11:0] : wtrue_nxt[11:0];
    height_nxt  = (seven_s_nxt + PAD_YY_RND) & ~7'd1;
    hrep_nxt    = (height_nxt > HEIGHT_MAX) ? HEIGHT_MAX : height_nxt;
    recip_s_nxt = recip_scale(scale_nxt);
    recip_p_nxt = recip_pitch(scale_nxt);
    fg_nxt      = {1'b1, font_color_nxt[23:19], font_color_nxt[15:11], font_color_nxt[7:3]};
    bg_nxt      = bg_on_nxt ? PIX_ALPHA : 16'h0000;
  end

  always_ff @(posedge clk) begin
    font_size_r  <= font_size_nxt;
    font_color_r <= font_color_nxt;
    bg_on_r      <= bg_on_nxt;
    text_len_r   <= text_len_nxt;
    scale_r      <= scale_nxt;
    pitch_r      <= pitch_nxt;
    five_s_r     <= five_s_nxt;
    seven_s_r    <= seven_s_nxt;
    len_r        <= len_nxt;
    wtrue_r      <= wtrue_nxt;
    wrep_r       <= wrep_nxt;
    height_r     <= height_nxt;
    hrep_r       <= hrep_nxt;
    recip_s_r    <= recip_s_nxt;
    recip_p_r    <= recip_p_nxt;
    fg_r         <= fg_nxt;
    bg_r         <= bg_nxt;
  end

  // pipeline control
  logic adv;
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_tvalid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      out_vld_r <= s4_vld_r;
    end
  end

  // stage 1: bounds, offsets and first quotient estimates
  logic        in_op;
  logic [5:0]  in_idx;
  logic [7:0]  in_code;
  logic [11:0] in_x;
  logic [6:0]  in_y;
  logic [11:0] rx_c;
  logic [6:0]  ry_c;
  logic [27:0] prod_x_c;
  logic [22:0] prod_y_c;

  assign in_op   = in_tuser[0];
  assign in_idx  = in_tdata[5:0];
  assign in_code = in_tdata[13:6];
  assign in_x    = in_tdata[25:14];
  assign in_y    = in_tdata[32:26];

  assign rx_c     = in_x - PAD_X;
  assign ry_c     = in_y - PAD_Y;
  assign prod_x_c = {16'b0, rx_c} * {12'b0, recip_p_r};
  assign prod_y_c = {16'b0, ry_c} * {7'b0, recip_s_r};

  logic        s1_op_r, s1_idx_ok_r, s1_band_r, s1_inside_r;
  logic [5:0]  s1_idx_r;
  logic [7:0]  s1_code_r;
  logic [11:0] s1_rx_r;
  logic [6:0]  s1_ry_r;
  logic [9:0]  s1_q1_r;
  logic [6:0]  s1_qy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r     <= in_op;
      s1_idx_r    <= in_idx;
      s1_code_r   <= in_code;
      s1_idx_ok_r <= {3'b0, in_idx} < 9'(MAX_CHARS);
      s1_rx_r     <= rx_c;
      s1_ry_r     <= ry_c;
      s1_q1_r     <= prod_x_c[RECIP_SHIFT +: 10];
      s1_qy_r     <= prod_y_c[RECIP_SHIFT +: 7];
      s1_band_r   <= (in_x >= PAD_X) && (in_y >= PAD_Y) && (ry_c < seven_s_r);
      s1_inside_r <= ({2'b0, in_x} < wtrue_r) && (in_y < height_r);
    end
  end

  // stage 2: remainders of the estimates
  logic [15:0] qp_c;
  logic [11:0] rdiff_x_c;
  logic [10:0] qsy_c;
  logic [6:0]  rdiff_y_c;

  assign qp_c      = {6'b0, s1_q1_r} * {10'b0, pitch_r};
  assign rdiff_x_c = s1_rx_r - qp_c[11:0];
  assign qsy_c     = {4'b0, s1_qy_r} * {7'b0, scale_r};
  assign rdiff_y_c = s1_ry_r - qsy_c[6:0];

  logic        s2_op_r, s2_idx_ok_r, s2_band_r, s2_inside_r;
  logic [5:0]  s2_idx_r;
  logic [7:0]  s2_code_r;
  logic [9:0]  s2_q1_r;
  logic [6:0]  s2_r1_r;
  logic [6:0]  s2_qy_r;
  logic [4:0]  s2_ryr_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op_r     <= s1_op_r;
      s2_idx_r    <= s1_idx_r;
      s2_code_r   <= s1_code_r;
      s2_idx_ok_r <= s1_idx_ok_r;
      s2_q1_r     <= s1_q1_r;
      s2_r1_r     <= rdiff_x_c[6:0];
      s2_qy_r     <= s1_qy_r;
      s2_ryr_r    <= rdiff_y_c[4:0];
      s2_band_r   <= s1_band_r;
      s2_inside_r <= s1_inside_r;
    end
  end

  // stage 3: corrected cell, offset and row; text store access
  logic        fix_x_c, fix_y_c;
  logic [9:0]  cell_c;
  logic [6:0]  off_full_c;
  logic [6:0]  gy_full_c;
  logic [5:0]  off_c;
  logic        ok_c;
  logic        ram_we;
  logic [7:0]  ram_rdata;

  assign fix_x_c    = s2_r1_r >= {1'b0, pitch_r};
  assign cell_c     = s2_q1_r + 10'(fix_x_c);
  assign off_full_c = fix_x_c ? (s2_r1_r - {1'b0, pitch_r}) : s2_r1_r;
  assign off_c      = off_full_c[5:0];
  assign fix_y_c    = s2_ryr_r >= {1'b0, scale_r};
  assign gy_full_c  = s2_qy_r + 7'(fix_y_c);
  assign ok_c       = s2_band_r && (cell_c < 10'(len_r)) && (off_c < five_s_r);

  // writes and reads meet the store at the same stage, so item order holds
  assign ram_we = adv && s2_vld_r && (s2_op_r == OP_WRITE) && s2_idx_ok_r;

  otpg_ram #(
    .WIDTH (8),
    .DEPTH (MAX_CHARS)
  ) u_text_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(s2_idx_r)),
    .wdata (s2_code_r),
    .re    (adv),
    .raddr (ADDR_W'(cell_c)),
    .rdata (ram_rdata)
  );

  logic        s3_op_r, s3_ok_r, s3_inside_r;
  logic [5:0]  s3_off_r;
  logic [2:0]  s3_gy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_op_r     <= s2_op_r;
      s3_ok_r     <= ok_c;
      s3_inside_r <= s2_inside_r;
      s3_off_r    <= off_c;
      s3_gy_r     <= gy_full_c[2:0];
    end
  end

  // stage 4: glyph row lookup and column estimate
  logic [21:0] prod_gx_c;

  assign prod_gx_c = {16'b0, s3_off_r} * {6'b0, recip_s_r};

  logic        s4_op_r, s4_ok_r, s4_inside_r;
  logic [5:0]  s4_off_r;
  logic [5:0]  s4_gxp_r;
  logic [4:0]  s4_bits_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_op_r     <= s3_op_r;
      s4_ok_r     <= s3_ok_r;
      s4_inside_r <= s3_inside_r;
      s4_off_r    <= s3_off_r;
      s4_gxp_r    <= prod_gx_c[RECIP_SHIFT +: 6];
      s4_bits_r   <= glyph_row(ram_rdata, s3_gy_r);
    end
  end

  // stage 5: column correction, bit pick and color
  logic [9:0]  gs_c;
  logic [9:0]  rem_full_c;
  logic [5:0]  gx_c;
  logic        on_c;
  logic        hit_c;
  logic [15:0] pix_c;

  assign gs_c       = {4'b0, s4_gxp_r} * {6'b0, scale_r};
  assign rem_full_c = {4'b0, s4_off_r} - gs_c;
  assign gx_c       = s4_gxp_r + 6'(rem_full_c[4:0] >= {1'b0, scale_r});
  assign on_c       = s4_ok_r && (|(s4_bits_r & (5'b10000 >> gx_c)));
  assign hit_c      = (s4_op_r == OP_PIXEL) && s4_inside_r;
  assign pix_c      = hit_c ? (on_c ? fg_r : bg_r) : 16'h0000;

  logic [15:0] out_pix_r;
  logic        out_inside_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix_r    <= pix_c;
      out_inside_r <= hit_c;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0, hrep_r, wrep_r, out_inside_r, out_pix_r};

endmodule

[sv/otpg_chk.sv]
// ----------------------------------------------------------------------------
// otpg_chk
// Port-level checks for the OSD text pixel generator, bound to the top level.
// ----------------------------------------------------------------------------
module otpg_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [otpg_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a waiting item holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("output item changed while stalled");

  // a stalled output stops intake
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while output stalled");

  // outside pixels and writes are transparent
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[16]) |-> (out_tdata[15:0] == 16'h0000))
    else $error("nonzero pixel outside the bitmap");

  // bitmap sizes are even
  a_even_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[17] && !out_tdata[29]))
    else $error("odd bitmap size");

  // drawn pixels are opaque or fully transparent
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[16]) |-> (out_tdata[15] || (out_tdata[15:0] == 16'h0000)))
    else $error("inside pixel without alpha");

endmodule

bind osd_text_pixel_generator otpg_chk u_otpg_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
